@@ hw/rtl/dbxy_pkg.sv @@
// ----------------------------------------------------------------------------
// dbxy_pkg
// Shared types, constants and helpers for the double-buffered XY player.
// ----------------------------------------------------------------------------
package dbxy_pkg;

	// Sample, gain, offset and active-length widths
	localparam int SMP_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int PHASE_W = 12;
	localparam int ACT_W   = 13;

	// Stream word widths
	localparam int IN_W  = 2 * SMP_W;
	localparam int OUT_W = 48;

	// Config port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_LEFT    = 3'd0,
		CFG_GAIN_RIGHT   = 3'd1,
		CFG_MASTER_GAIN  = 3'd2,
		CFG_PHASE_OFFSET = 3'd3,
		CFG_PLAY_ENABLE  = 3'd4
	} cfg_idx_t;

	// Request kinds carried on tuser
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Gain defaults: 1.0 in Q4.12
	localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd4096;

	// Width of the scaled product, and its width after the rounding shift
	localparam int PROD_W = 50;
	localparam int RND_W  = PROD_W - 24;

	// Clamp a rounded product to Q1.15
	function automatic logic signed [SMP_W-1:0] sat16(input logic signed [RND_W-1:0] v);
		logic signed [SMP_W-1:0] r;
		if (v > RND_W'(32767)) begin
			r = 16'sh7FFF;
		end else if (v < -(RND_W'(32768))) begin
			r = 16'sh8000;
		end else begin
			r = v[SMP_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/dbxy_ram.sv @@
// ----------------------------------------------------------------------------
// dbxy_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dbxy_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/double_buffered_xy_wavetable_player.sv @@
// ----------------------------------------------------------------------------
// double_buffered_xy_wavetable_player
// Stereo XY path player with a front (playing) and a back (loading) bank.
// ----------------------------------------------------------------------------
// A load word (tuser = 0) writes one left/right sample pair into the back bank
// and is taken whenever the player is idle; tlast commits the path length and
// arms a swap. A tick word (tuser = 1) does any armed swap, then returns one
// scaled, saturated sample pair plus the front bank length. A tick runs
// through accept, bank read, two multiply stages and the output register. A
// silent tick (play disabled or empty front bank) skips the read and multiply
// stages and goes straight to the output register. After reset, a swap or a
// phase_offset write the first audible tick also runs a bit-serial modulo of
// the right read offset by the bank length. Both banks live in two RAMs of
// 2*2^$clog2(BANK_DEPTH) entries with registered reads; entries are not
// cleared at reset, so there is no clearing pass. A load is accepted while a
// finished tick result still waits on the output.
// ----------------------------------------------------------------------------
module double_buffered_xy_wavetable_player
	import dbxy_pkg::*;
#(
	parameter int BANK_DEPTH = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// Request stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_W-1:0]       s_axis_tdata,   // left_in[15:0], right_in[31:16]
	input  logic                  s_axis_tuser,   // req_type
	input  logic                  s_axis_tlast,   // load_last

	// Result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata,   // left_out[15:0], right_out[31:16],
	                                              // active_length[44:32], zero pad

	// Config write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W  = $clog2(BANK_DEPTH);
	localparam int LEN_W  = $clog2(BANK_DEPTH + 1);
	localparam int ADDR_W = IDX_W + 1;
	localparam int X_W    = $clog2(BANK_DEPTH + 4095);
	localparam int CNT_W  = $clog2(X_W + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_MUL1,
		ST_MUL2,
		ST_OUT
	} state_t;

	state_t state_q;

	// Config registers
	logic [GAIN_W-1:0]  gain_left_q;
	logic [GAIN_W-1:0]  gain_right_q;
	logic [GAIN_W-1:0]  master_gain_q;
	logic [PHASE_W-1:0] phase_q;
	logic               play_en_q;

	// Player state
	logic [LEN_W-1:0]   len_q [2];
	logic               front_q;
	logic               armed_q;
	logic               stale_q;
	logic [IDX_W-1:0]   play_q;
	logic [IDX_W-1:0]   rpos_q;
	logic [LEN_W-1:0]   load_idx_q;
	logic [CNT_W-1:0]   mod_cnt_q;
	logic               m_valid_q;

	// Datapath registers
	logic [X_W-1:0]            mod_x_q;
	logic [LEN_W-1:0]          mod_rem_q;
	logic                      silent_q;
	logic signed [32:0]        sg_l_s1;
	logic signed [32:0]        sg_r_s1;
	logic signed [PROD_W-1:0]  p_l_s2;
	logic signed [PROD_W-1:0]  p_r_s2;
	logic [OUT_W-1:0]          out_q;

	// Handshakes
	logic in_acc, is_load, is_tick, out_free;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign is_load       = in_acc & (s_axis_tuser == REQ_LOAD);
	assign is_tick       = in_acc & (s_axis_tuser == REQ_TICK);
	assign cfg_ready     = 1'b1;
	assign out_free      = ~m_valid_q | m_axis_tready;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_q;

	// Load side
	logic             back;
	logic             load_wr;
	logic [LEN_W-1:0] load_inc;
	assign back     = ~front_q;
	assign load_wr  = is_load & (load_idx_q < LEN_W'(BANK_DEPTH));
	assign load_inc = load_idx_q + LEN_W'(1);

	// Tick setup: swap first, then look at the new front length
	logic             front_nx;
	logic [LEN_W-1:0] len_nx;
	logic [IDX_W-1:0] play_nx;
	logic             silent_nx;
	assign front_nx  = armed_q ? ~front_q : front_q;
	assign len_nx    = len_q[front_nx];
	assign play_nx   = armed_q ? '0 : play_q;
	assign silent_nx = ~play_en_q | (len_nx == '0);

	logic [LEN_W-1:0] cur_len;
	assign cur_len = len_q[front_q];

	// One restoring modulo step
	logic [LEN_W:0]   rem_sh;
	logic [LEN_W-1:0] rem_nx;
	assign rem_sh = {mod_rem_q, mod_x_q[X_W-1]};
	assign rem_nx = (rem_sh >= {1'b0, cur_len}) ? LEN_W'(rem_sh - {1'b0, cur_len})
	                                            : LEN_W'(rem_sh);

	// Wrapping increments of the two read positions
	logic [LEN_W-1:0] play_inc, rpos_inc;
	assign play_inc = LEN_W'(play_q) + LEN_W'(1);
	assign rpos_inc = LEN_W'(rpos_q) + LEN_W'(1);

	// Bank RAMs
	logic              rd_en;
	logic [ADDR_W-1:0] waddr, raddr_l, raddr_r;
	logic [SMP_W-1:0]  rdata_l, rdata_r;
	assign rd_en   = (state_q == ST_READ);
	assign waddr   = {back, load_idx_q[IDX_W-1:0]};
	assign raddr_l = {front_q, play_q};
	assign raddr_r = {front_q, rpos_q};

	dbxy_ram #(
		.WIDTH(SMP_W),
		.DEPTH(2 ** ADDR_W)
	) u_left_ram (
		.clk  (clk),
		.we   (load_wr),
		.waddr(waddr),
		.wdata(s_axis_tdata[SMP_W-1:0]),
		.re   (rd_en),
		.raddr(raddr_l),
		.rdata(rdata_l)
	);

	dbxy_ram #(
		.WIDTH(SMP_W),
		.DEPTH(2 ** ADDR_W)
	) u_right_ram (
		.clk  (clk),
		.we   (load_wr),
		.waddr(waddr),
		.wdata(s_axis_tdata[IN_W-1:SMP_W]),
		.re   (rd_en),
		.raddr(raddr_r),
		.rdata(rdata_r)
	);

	// Control: state, config, bank bookkeeping, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			gain_left_q   <= GAIN_ONE;
			gain_right_q  <= GAIN_ONE;
			master_gain_q <= GAIN_ONE;
			phase_q       <= '0;
			play_en_q     <= 1'b0;
			len_q[0]      <= '0;
			len_q[1]      <= '0;
			front_q       <= 1'b0;
			armed_q       <= 1'b0;
			stale_q       <= 1'b1;
			play_q        <= '0;
			rpos_q        <= '0;
			load_idx_q    <= '0;
			mod_cnt_q     <= '0;
			m_valid_q     <= 1'b0;
		end else begin
			// config writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_GAIN_LEFT:    gain_left_q   <= cfg_data;
					CFG_GAIN_RIGHT:   gain_right_q  <= cfg_data;
					CFG_MASTER_GAIN:  master_gain_q <= cfg_data;
					CFG_PHASE_OFFSET: phase_q       <= cfg_data[PHASE_W-1:0];
					CFG_PLAY_ENABLE:  play_en_q     <= cfg_data[0];
					default: ;
				endcase
			end

			// right offset needs a fresh modulo after a swap or a phase write
			if (cfg_valid && cfg_ready && (cfg_idx_t'(cfg_index) == CFG_PHASE_OFFSET)) begin
				stale_q <= 1'b1;
			end else if (is_tick && armed_q) begin
				stale_q <= 1'b1;
			end else if (state_q == ST_MOD && mod_cnt_q == CNT_W'(1)) begin
				stale_q <= 1'b0;
			end

			// output word taken; a new word in ST_OUT takes its place
			if (m_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (is_load) begin
						if (s_axis_tlast) begin
							len_q[back] <= load_wr ? load_inc : load_idx_q;
							load_idx_q  <= '0;
							armed_q     <= 1'b1;
						end else if (load_wr) begin
							load_idx_q <= load_inc;
						end
					end else if (is_tick) begin
						front_q <= front_nx;
						play_q  <= play_nx;
						if (armed_q) begin
							armed_q <= 1'b0;
						end
						mod_cnt_q <= CNT_W'(X_W);
						if (silent_nx) begin
							state_q <= ST_OUT;
						end else if (stale_q || armed_q) begin
							state_q <= ST_MOD;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_MOD: begin
					mod_cnt_q <= mod_cnt_q - CNT_W'(1);
					if (mod_cnt_q == CNT_W'(1)) begin
						rpos_q  <= IDX_W'(rem_nx);
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					// RAMs sample the current positions at this edge
					play_q  <= (play_inc == cur_len) ? '0 : IDX_W'(play_inc);
					rpos_q  <= (rpos_inc == cur_len) ? '0 : IDX_W'(rpos_inc);
					state_q <= ST_MUL1;
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: modulo shift register, gain stages, output word
	logic signed [PROD_W-1:0] rnd_l, rnd_r;
	assign rnd_l = p_l_s2 + PROD_W'(64'sd8388608);
	assign rnd_r = p_r_s2 + PROD_W'(64'sd8388608);

	always_ff @(posedge clk) begin
		if (is_tick) begin
			silent_q  <= silent_nx;
			mod_x_q   <= X_W'(play_nx) + X_W'(phase_q);
			mod_rem_q <= '0;
		end
		if (state_q == ST_MOD) begin
			mod_rem_q <= rem_nx;
			mod_x_q   <= mod_x_q << 1;
		end
		// sample times channel gain
		if (state_q == ST_MUL1) begin
			sg_l_s1 <= 33'($signed(rdata_l)) * 33'($signed({1'b0, gain_left_q}));
			sg_r_s1 <= 33'($signed(rdata_r)) * 33'($signed({1'b0, gain_right_q}));
		end
		// times master gain
		if (state_q == ST_MUL2) begin
			p_l_s2 <= PROD_W'(sg_l_s1) * PROD_W'($signed({1'b0, master_gain_q}));
			p_r_s2 <= PROD_W'(sg_r_s1) * PROD_W'($signed({1'b0, master_gain_q}));
		end
		// round, clamp and pack
		if (state_q == ST_OUT && out_free) begin
			out_q[OUT_W-1:2*SMP_W+ACT_W]      <= '0;
			out_q[2*SMP_W+ACT_W-1:2*SMP_W]    <= ACT_W'(cur_len);
			if (silent_q) begin
				out_q[2*SMP_W-1:0] <= '0;
			end else begin
				out_q[SMP_W-1:0]       <= sat16(rnd_l[PROD_W-1:24]);
				out_q[2*SMP_W-1:SMP_W] <= sat16(rnd_r[PROD_W-1:24]);
			end
		end
	end

endmodule
